// ===== rtl/core/rsepe_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the erasure parity encoder.
// No dependencies; every other file in rtl/core except rsepe_queue refers to this package.
package rsepe_pkg;

    localparam int BYTE_W = 8;
    localparam int SLOT_W = 4;
    localparam int LANES_MAX = 16;
    localparam int SLOTS = 16;
    localparam logic [8:0] GF_POLY = 9'h11d;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [SLOT_W-1:0] chunk_slot;
        logic              column_end;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] check_byte;
        logic [SLOT_W-1:0] parity_slot;
        logic              last_parity;
    } out_word_t;

    // Shift-and-add multiply, reduced by x^8 + x^4 + x^3 + x^2 + 1.
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0]   x;
        logic [BYTE_W-1:0] p;
        x = {1'b0, a};
        p = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (b[k])
            begin
                p = p ^ x[BYTE_W-1:0];
            end
            x = {x[BYTE_W-1:0], 1'b0};
            if (x[BYTE_W])
            begin
                x = x ^ GF_POLY;
            end
        end
        return p;
    endfunction

    // Only evaluated on constants, to build the coefficient tables.
    function automatic logic [BYTE_W-1:0] gf_pow(input logic [BYTE_W-1:0] a,
                                                 input logic [SLOT_W-1:0] n);
        logic [BYTE_W-1:0] r;
        r = 8'h01;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (k < int'(n))
            begin
                r = gf_mul(r, a);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rsepe_front.sv =====
// Front end: takes input words, looks up one generator coefficient per lane
// and builds the queue entry {coefficients, byte, end flag}. Uses rsepe_pkg.
module rsepe_front #(
    parameter int DATA_CHUNKS = 16,
    parameter int LANES = 16,
    parameter int QW = LANES * rsepe_pkg::BYTE_W + rsepe_pkg::BYTE_W + 1
) (
    input  logic                in_valid,
    output logic                in_ready,
    input  rsepe_pkg::in_word_t in_word,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [QW-1:0]       push_data
);

    logic                                  use_slot;
    logic [LANES*rsepe_pkg::BYTE_W-1:0]    coef_row;

    // Slots past the data chunks get zero coefficients, so they add nothing.
    assign use_slot = ({4'b0000, in_word.chunk_slot} < 8'(DATA_CHUNKS));

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [rsepe_pkg::BYTE_W-1:0] coef_tab [rsepe_pkg::SLOTS];
        for (genvar j = 0; j < rsepe_pkg::SLOTS; j++)
        begin : g_slot
            assign coef_tab[j] = rsepe_pkg::gf_pow(8'(DATA_CHUNKS + i), 4'(j));
        end
        assign coef_row[i*rsepe_pkg::BYTE_W +: rsepe_pkg::BYTE_W] =
            use_slot ? coef_tab[in_word.chunk_slot] : 8'h00;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign push_data  = {coef_row, in_word.data_byte, in_word.column_end};

endmodule

// ===== rtl/core/rsepe_queue.sv =====
// Small register FIFO between the front end and the accumulator back end.
// Generic in width and depth; no package dependencies.
module rsepe_queue #(
    parameter int WIDTH = 137,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             take_valid,
    input  logic             take_ready,
    output logic [WIDTH-1:0] take_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;
    logic             take_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign take_valid = (count_reg != '0);
    assign take_data  = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign take_fire  = take_valid && take_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !take_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/rsepe_back.sv =====
// Back end: GF multiply-accumulate into one register per parity lane, and a
// drain buffer that emits the finished parity words in lane order. Uses rsepe_pkg.
module rsepe_back #(
    parameter int LANES = 16,
    parameter int QW = LANES * rsepe_pkg::BYTE_W + rsepe_pkg::BYTE_W + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take_valid,
    output logic                  take_ready,
    input  logic [QW-1:0]         take_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rsepe_pkg::out_word_t  out_word
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [rsepe_pkg::BYTE_W-1:0] acc_reg  [LANES];
    logic [rsepe_pkg::BYTE_W-1:0] hold_reg [LANES];
    logic [rsepe_pkg::BYTE_W-1:0] sum      [LANES];
    logic [IDX_W-1:0]             idx_reg;
    logic                         busy_reg;
    logic                         head_end;
    logic [rsepe_pkg::BYTE_W-1:0] head_byte;
    logic                         take_fire;
    logic                         out_fire;
    logic                         drain_last;

    assign head_end  = take_data[0];
    assign head_byte = take_data[rsepe_pkg::BYTE_W:1];

    for (genvar i = 0; i < LANES; i++)
    begin : g_mac
        assign sum[i] = acc_reg[i] ^ rsepe_pkg::gf_mul(
            take_data[rsepe_pkg::BYTE_W + 1 + i*rsepe_pkg::BYTE_W +: rsepe_pkg::BYTE_W],
            head_byte);
    end

    assign drain_last = (idx_reg == IDX_W'(LANES - 1));
    assign out_fire   = out_valid && out_ready;
    // Hold an end word at the queue head until the drain buffer frees up.
    assign take_ready = !head_end || !busy_reg || (out_ready && drain_last);
    assign take_fire  = take_valid && take_ready;

    assign out_valid            = busy_reg;
    assign out_word.check_byte  = hold_reg[idx_reg];
    assign out_word.parity_slot = rsepe_pkg::SLOT_W'(idx_reg);
    assign out_word.last_parity = drain_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            // A new drain starting takes priority over the end of the old one.
            if (take_fire && head_end)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (out_fire)
            begin
                if (drain_last)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (take_fire)
            begin
                if (head_end)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        acc_reg[i] <= sum[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_fire && head_end)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                hold_reg[i] <= sum[i];
            end
        end
    end

endmodule

// ===== rtl/core/rs_erasure_parity_encoder_unit.sv =====
// Reed-Solomon erasure parity encoder over GF(2^8) (polynomial 0x11d). It takes
// one data word per cycle while the queue has room; lane i adds
// byte * (DATA_CHUNKS + i)^slot into its accumulator, all lanes at once, so
// accumulation runs at one word per clock. A word with column_end set closes
// the position: its sums move into a drain buffer and min(PARITY_CHUNKS, 16)
// parity words leave in lane order, one per cycle while out_ready is high, the
// last one flagged, while new data keeps accumulating behind them. The drain
// buffer sets the limit: an end word that arrives while a drain is still
// running waits at the head of the four-entry queue. Depends on rsepe_pkg and
// the rsepe_* modules.
module rs_erasure_parity_encoder_unit #(
    parameter int DATA_CHUNKS = 16,
    parameter int PARITY_CHUNKS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rsepe_pkg::in_word_t   in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rsepe_pkg::out_word_t  out_word
);

    localparam int LANES = (PARITY_CHUNKS < rsepe_pkg::LANES_MAX) ?
                           PARITY_CHUNKS : rsepe_pkg::LANES_MAX;
    localparam int QW = LANES * rsepe_pkg::BYTE_W + rsepe_pkg::BYTE_W + 1;
    localparam int QUEUE_DEPTH = 4;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          take_valid;
    logic          take_ready;
    logic [QW-1:0] take_data;

    rsepe_front #(
        .DATA_CHUNKS (DATA_CHUNKS),
        .LANES       (LANES),
        .QW          (QW)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rsepe_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .take_valid (take_valid),
        .take_ready (take_ready),
        .take_data  (take_data)
    );

    rsepe_back #(
        .LANES (LANES),
        .QW    (QW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .take_valid (take_valid),
        .take_ready (take_ready),
        .take_data  (take_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule

// ===== verif/rs_erasure_parity_encoder_unit_test.sv =====
// Self-checking testbench for rs_erasure_parity_encoder_unit: directed and random byte columns.
// Predicts parity with its own GF(2^8) arithmetic. Depends on rsepe_pkg and the RTL only.
module rs_erasure_parity_encoder_unit_test;

    localparam int DATA_CHUNKS = 16;
    localparam int PARITY_CHUNKS = 16;
    localparam int LANE_COUNT = (PARITY_CHUNKS < rsepe_pkg::LANES_MAX) ?
                                PARITY_CHUNKS : rsepe_pkg::LANES_MAX;
    localparam logic [7:0] POLY_LOW = rsepe_pkg::GF_POLY[7:0];
    localparam int RANDOM_TARGET = 310;
    localparam int TAIL_CYCLES = 48;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SHOWN_MISMATCHES = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    rsepe_pkg::in_word_t  in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    rsepe_pkg::out_word_t out_word;

    logic [7:0]           lane_sums [LANE_COUNT];
    rsepe_pkg::out_word_t parity_due [$];
    int                   words_sent = 0;
    int                   mismatches = 0;
    int                   cycles = 0;
    bit                   feed_steady = 1'b0;
    bit                   drain_steady = 1'b0;

    rs_erasure_parity_encoder_unit #(
        .DATA_CHUNKS(DATA_CHUNKS),
        .PARITY_CHUNKS(PARITY_CHUNKS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("rs_erasure_parity_encoder_unit_test NOT OK");
            $finish;
        end
    end

    // Horner form over the bits of a, reducing on every doubling.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 7; k >= 0; k--)
        begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? POLY_LOW : 8'h00);
            if (a[k])
            begin
                acc = acc ^ b;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] lane_coef(input int lane, input int slot);
        logic [7:0] point;
        logic [7:0] r;
        point = 8'((DATA_CHUNKS + lane) % 256);
        r = 8'h01;
        for (int k = 0; k < slot; k++)
        begin
            r = gf_times(r, point);
        end
        return r;
    endfunction

    function automatic void fold_word(input rsepe_pkg::in_word_t w);
        rsepe_pkg::out_word_t p;
        if (int'(w.chunk_slot) < DATA_CHUNKS)
        begin
            for (int lane = 0; lane < LANE_COUNT; lane++)
            begin
                lane_sums[lane] ^= gf_times(lane_coef(lane, int'(w.chunk_slot)), w.data_byte);
            end
        end
        if (w.column_end)
        begin
            for (int lane = 0; lane < LANE_COUNT; lane++)
            begin
                p.check_byte = lane_sums[lane];
                p.parity_slot = 4'(lane);
                p.last_parity = 1'(lane == LANE_COUNT - 1);
                parity_due.insert(parity_due.size(), p);
                lane_sums[lane] = 8'h00;
            end
        end
    endfunction

    function automatic void note_mismatch(input string what, input rsepe_pkg::out_word_t exp,
                                          input rsepe_pkg::out_word_t got);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
        begin
            $display("mismatch (%s): expected byte %02h slot %0d last %0b,",
                     what, exp.check_byte, exp.parity_slot, exp.last_parity);
            $display("    got byte %02h slot %0d last %0b",
                     got.check_byte, got.parity_slot, got.last_parity);
        end
    endfunction

    // Result checker: compare each accepted parity word with the oldest one due.
    always @(posedge clk)
    begin
        rsepe_pkg::out_word_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (parity_due.size() == 0)
            begin
                note_mismatch("unexpected word", '0, out_word);
            end
            else
            begin
                exp = parity_due[0];
                parity_due.delete(0);
                if (out_word.check_byte !== exp.check_byte)
                    note_mismatch("check_byte", exp, out_word);
                else if (out_word.parity_slot !== exp.parity_slot)
                    note_mismatch("parity_slot", exp, out_word);
                else if (out_word.last_parity !== exp.last_parity)
                    note_mismatch("last_parity", exp, out_word);
            end
        end
    end

    // Receiver: stall a random number of cycles before each parity word, unless drain_steady is set.
    always
    begin
        int stall;
        stall = drain_steady ? 0 : $urandom_range(0, 17);
        if (stall > 0)
        begin
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(rst_n && out_valid && out_ready))
        begin
            @(posedge clk);
        end
    end

    // Hold valid and payload until accepted; drop valid only across a gap.
    task automatic send_word(input logic [7:0] data, input logic [3:0] slot, input logic last);
        int gap;
        rsepe_pkg::in_word_t w;
        gap = feed_steady ? 0 : $urandom_range(0, 17);
        w.data_byte = data;
        w.chunk_slot = slot;
        w.column_end = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        fold_word(w);
        words_sent++;
    endtask

    task automatic test_lone_end_word();
        send_word(8'h00, 4'd0, 1'b1);
    endtask

    task automatic test_coefficient_columns();
        send_word(8'h01, 4'd0, 1'b1);
        send_word(8'h01, 4'd1, 1'b1);
        send_word(8'h01, 4'd15, 1'b1);
        send_word(8'hff, 4'd15, 1'b1);
        send_word(8'h80, 4'd7, 1'b1);
    endtask

    task automatic test_repeated_slot();
        send_word(8'h5a, 4'd3, 1'b0);
        send_word(8'h5a, 4'd3, 1'b0);
        send_word(8'h5a, 4'd3, 1'b1);
    endtask

    task automatic test_open_position();
        send_word(8'hff, 4'd0, 1'b0);
        send_word(8'h00, 4'd5, 1'b0);
        send_word(8'haa, 4'd10, 1'b0);
        send_word(8'h55, 4'd12, 1'b0);
        send_word(8'hff, 4'd15, 1'b0);
        send_word(8'h01, 4'd8, 1'b1);
    endtask

    task automatic test_back_to_back_ends();
        feed_steady = 1'b1;
        send_word(8'h3c, 4'd2, 1'b1);
        send_word(8'hc3, 4'd9, 1'b1);
        send_word(8'hff, 4'd15, 1'b1);
        send_word(8'h7e, 4'd4, 1'b1);
        feed_steady = 1'b0;
    endtask

    // Mostly in-order columns of random length; the rest is loose words with random slots.
    task automatic test_random_positions();
        int n;
        int span;
        span = (DATA_CHUNKS > 16) ? 16 : DATA_CHUNKS;
        while (words_sent < RANDOM_TARGET)
        begin
            feed_steady = ($urandom_range(0, 3) == 0);
            drain_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) != 0)
            begin
                n = $urandom_range(1, span);
                for (int j = 0; j < n; j++)
                begin
                    send_word(8'($urandom), 4'(j), 1'(j == n - 1));
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++)
                begin
                    send_word(8'($urandom), 4'($urandom), 1'($urandom_range(0, 3) == 0));
                end
            end
        end
        feed_steady = 1'b0;
        drain_steady = 1'b0;
    endtask

    initial
    begin
        for (int lane = 0; lane < LANE_COUNT; lane++)
        begin
            lane_sums[lane] = 8'h00;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lone_end_word();
        test_coefficient_columns();
        test_repeated_slot();
        test_open_position();
        test_back_to_back_ends();
        test_random_positions();
        // Close any open column so trailing data is checked too.
        send_word(8'($urandom), 4'($urandom), 1'b1);
        in_valid <= 1'b0;
        while (parity_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("rs_erasure_parity_encoder_unit_test OK");
        end
        else
        begin
            $display("rs_erasure_parity_encoder_unit_test NOT OK");
        end
        $finish;
    end

endmodule
